>>> rtl/page_frame_free_list_allocator_defines.svh
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PFFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define PFFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/pffl_pkg.sv
package pffl_pkg;

  localparam int unsigned PAGE_COUNT  = 128;
  localparam int unsigned IDX_W       = $clog2(PAGE_COUNT);
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned FRAME_SHIFT = 12;  // 4 KiB rounding of the kernel end
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 8;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_LINK  = 2'd2;

  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    link_t            wr_data;
  } link_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_status_t;

  typedef struct packed {
    logic             ok;
    logic             addr_en;
    logic [IDX_W-1:0] head_index;
    logic [IDX_W-1:0] link_index;
    logic             link_end;
    logic [IDX_W-1:0] free_head;
    logic             free_empty;
  } result_t;

  // link of an entry that was never written since reset
  function automatic link_t link_reset(input logic [IDX_W-1:0] idx);
    link_t r;
    r.last = (idx == IDX_W'(PAGE_COUNT - 1));
    r.idx  = r.last ? '0 : idx + 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/pffl_ram.sv
module pffl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pffl_links.sv
module pffl_links (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pffl_pkg::link_req_t req_i,
  output pffl_pkg::link_t     rdata_o
);

  logic [pffl_pkg::PAGE_COUNT-1:0] valid_q;
  logic                            rd_valid_q;
  logic [pffl_pkg::IDX_W-1:0]      rd_addr_q;
  pffl_pkg::link_t                 ram_rdata;

  pffl_ram #(
    .Width($bits(pffl_pkg::link_t)),
    .Depth(pffl_pkg::PAGE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wr_data),
    .re_i   (req_i.rd_en),
    .raddr_i(req_i.rd_addr),
    .rdata_o(ram_rdata)
  );

  // one valid bit per entry, unwritten entries read as their reset link
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_addr_q <= req_i.rd_addr;
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : pffl_pkg::link_reset(rd_addr_q);

endmodule

>>> rtl/pffl_seq.sv
module pffl_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [1:0]                  mode_i,
  input  logic [pffl_pkg::CNT_W-1:0]  page_count_i,
  input  logic [pffl_pkg::IDX_W-1:0]  chain_head_i,
  input  logic                        chain_present_i,
  input  logic                        res_take_i,
  input  pffl_pkg::link_t             link_rdata_i,
  output pffl_pkg::link_req_t         link_req_o,
  output pffl_pkg::seq_status_t       status_o,
  output pffl_pkg::result_t           result_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [1:0]                 op_q, op_d;
  logic [pffl_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_step;
  logic [pffl_pkg::IDX_W-1:0] cur_q, cur_d;
  logic [pffl_pkg::IDX_W-1:0] start_q, start_d;
  logic [pffl_pkg::IDX_W-1:0] free_head_q, free_head_d;
  logic                       free_none_q, free_none_d;
  pffl_pkg::result_t          res_q, res_d;

  // shared counter unit: counts down the pages left to detach, or up the free walk steps
  assign cnt_step = (op_q == pffl_pkg::MODE_ALLOC) ? cnt_q - 1'b1 : cnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    start_d     = start_q;
    free_head_d = free_head_q;
    free_none_d = free_none_q;
    res_d       = res_q;
    link_req_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d              = mode_i;
          res_d             = '0;
          res_d.free_head   = free_head_q;
          res_d.free_empty  = free_none_q;
          state_d           = ST_DONE;
          case (mode_i)
            pffl_pkg::MODE_ALLOC: begin
              if (page_count_i != '0 && !free_none_q) begin
                link_req_o.rd_en   = 1'b1;
                link_req_o.rd_addr = free_head_q;
                cur_d              = free_head_q;
                start_d            = free_head_q;
                cnt_d              = page_count_i - 1'b1;
                state_d            = ST_WALK;
              end
            end
            pffl_pkg::MODE_FREE: begin
              if (!chain_present_i) begin
                res_d.ok = 1'b1;
              end else begin
                link_req_o.rd_en   = 1'b1;
                link_req_o.rd_addr = chain_head_i;
                cur_d              = chain_head_i;
                start_d            = chain_head_i;
                cnt_d              = '0;
                state_d            = ST_WALK;
              end
            end
            pffl_pkg::MODE_LINK: begin
              link_req_o.rd_en   = 1'b1;
              link_req_o.rd_addr = chain_head_i;
              state_d            = ST_WALK;
            end
            default: begin
              res_d.ok = 1'b0;
            end
          endcase
        end
      end

      ST_WALK: begin
        state_d = ST_DONE;
        case (op_q)
          pffl_pkg::MODE_ALLOC: begin
            if (cnt_q == '0) begin
              // tail of the detached chain: cut it off the free list
              link_req_o.wr_en        = 1'b1;
              link_req_o.wr_addr      = cur_q;
              link_req_o.wr_data.last = 1'b1;
              link_req_o.wr_data.idx  = '0;
              free_none_d             = link_rdata_i.last;
              free_head_d             = link_rdata_i.last ? '0 : link_rdata_i.idx;
              res_d.ok                = 1'b1;
              res_d.addr_en           = 1'b1;
              res_d.head_index        = start_q;
              res_d.free_head         = link_rdata_i.last ? '0 : link_rdata_i.idx;
              res_d.free_empty        = link_rdata_i.last;
            end else if (!link_rdata_i.last) begin
              link_req_o.rd_en   = 1'b1;
              link_req_o.rd_addr = link_rdata_i.idx;
              cur_d              = link_rdata_i.idx;
              cnt_d              = cnt_step;
              state_d            = ST_WALK;
            end
          end
          pffl_pkg::MODE_FREE: begin
            if (link_rdata_i.last) begin
              // splice the chain in front of the free list
              link_req_o.wr_en        = 1'b1;
              link_req_o.wr_addr      = cur_q;
              link_req_o.wr_data.last = free_none_q;
              link_req_o.wr_data.idx  = free_none_q ? '0 : free_head_q;
              free_head_d             = start_q;
              free_none_d             = 1'b0;
              res_d.ok                = 1'b1;
              res_d.free_head         = start_q;
              res_d.free_empty        = 1'b0;
            end else if (cnt_q != pffl_pkg::CNT_W'(pffl_pkg::PAGE_COUNT)) begin
              link_req_o.rd_en   = 1'b1;
              link_req_o.rd_addr = link_rdata_i.idx;
              cur_d              = link_rdata_i.idx;
              cnt_d              = cnt_step;
              state_d            = ST_WALK;
            end
          end
          pffl_pkg::MODE_LINK: begin
            res_d.ok         = 1'b1;
            res_d.link_end   = link_rdata_i.last;
            res_d.link_index = link_rdata_i.last ? '0 : link_rdata_i.idx;
          end
          default: begin
            res_d.ok = 1'b0;
          end
        endcase
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      free_none_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      free_none_q <= free_none_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cnt_q   <= cnt_d;
    cur_q   <= cur_d;
    start_q <= start_d;
    res_q   <= res_d;
  end

  assign status_o.idle = (state_q == ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);
  assign result_o      = res_q;

endmodule

>>> rtl/page_frame_free_list_allocator.sv
// allocate of n pages reads up to n link entries, free of a chain of length L reads L entries
// (walk capped at 129 reads), read link reads one; requests refused at input or no-ops read none
// the link walk does one link store read per cycle through the shared step counter
// one item at a time: the next item is taken the cycle after its result is registered
// reset: free list 0..last from per-entry valid bits, no clearing pass; kernel end 0
module page_frame_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // page_count[7:0], chain_head[14:8], chain_present[15]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // ok[0], head_index[7:1], head_address[39:8],
                                      // link_index[46:40], link_end[47],
                                      // free_head_index[54:48], free_empty[55]
  // kernel end address register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  `include "page_frame_free_list_allocator_defines.svh"

  localparam int unsigned BaseW = pffl_pkg::ADDR_W - pffl_pkg::FRAME_SHIFT;

  pffl_pkg::link_req_t   link_req;
  pffl_pkg::link_t       link_rdata;
  pffl_pkg::seq_status_t seq_st;
  pffl_pkg::result_t     seq_res;

  logic [BaseW-1:0]            base_hi_q;
  logic [pffl_pkg::ADDR_W-1:0] head_addr;
  logic                        res_load;
  logic                        out_valid_q;
  logic [55:0]                 out_data_q;

  // kernel end rounded up to a 4 KiB frame boundary at write time, wraps at 32 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_hi_q <= '0;
    end else if (cfg_we_i) begin
      base_hi_q <= cfg_wdata_i[pffl_pkg::ADDR_W-1:pffl_pkg::FRAME_SHIFT]
                 + BaseW'(|cfg_wdata_i[pffl_pkg::FRAME_SHIFT-1:0]);
    end
  end

  pffl_links u_links (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .rdata_o(link_rdata)
  );

  pffl_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .mode_i         (s_axis_tuser),
    .page_count_i   (s_axis_tdata[7:0]),
    .chain_head_i   (s_axis_tdata[14:8]),
    .chain_present_i(s_axis_tdata[15]),
    .res_take_i     (res_load),
    .link_rdata_i   (link_rdata),
    .link_req_o     (link_req),
    .status_o       (seq_st),
    .result_o       (seq_res)
  );

  assign s_axis_tready = seq_st.idle;

  // frame address of the allocated head, zero unless the allocation went through
  assign head_addr = seq_res.addr_en
                   ? {base_hi_q, pffl_pkg::FRAME_SHIFT'(0)}
                     + (pffl_pkg::ADDR_W'(seq_res.head_index) << pffl_pkg::PAGE_SHIFT)
                   : '0;

  // output register takes a finished result whenever its slot is free or draining
  assign res_load = seq_st.done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= {seq_res.free_empty, seq_res.free_head, seq_res.link_end,
                     seq_res.link_index, head_addr, seq_res.head_index, seq_res.ok};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a transfer in always starts a multi-cycle operation
  `PFFL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a link store write ends the walk
  `PFFL_ASSERT_NEXT(a_write_ends_walk, link_req.wr_en, seq_st.done)
  // a registered result is presented the cycle after it is loaded
  `PFFL_ASSERT_NEXT(a_load_shows_result, res_load, m_axis_tvalid)
  // the link store is never written while idle
  `PFFL_ASSERT_NOW(a_no_write_idle, seq_st.idle, !link_req.wr_en)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // mode code the block does not define, must be refused
  localparam logic [1:0] MODE_IDLE = 2'd3;
  // cycles without any transfer on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT = 3000;

  // result layout, first member is the top bit of m_axis_tdata
  typedef struct packed {
    logic        free_empty;
    logic [6:0]  free_head_index;
    logic        link_end;
    logic [6:0]  link_index;
    logic [31:0] head_address;
    logic [6:0]  head_index;
    logic        ok;
  } frame_result_t;

  // mirror of the free list, predicts one result per request
  class free_list_mirror;
    logic [6:0]    frame_next[pffl_pkg::PAGE_COUNT];
    bit            frame_tail[pffl_pkg::PAGE_COUNT];
    logic [6:0]    free_head;
    bit            list_empty;
    logic [31:0]   kernel_end;
    frame_result_t replies[$];
    int            errors;

    function new();
      for (int i = 0; i < pffl_pkg::PAGE_COUNT; i++) begin
        frame_next[i] = (i + 1 < pffl_pkg::PAGE_COUNT) ? 7'(i + 1) : 7'd0;
        frame_tail[i] = (i + 1 >= pffl_pkg::PAGE_COUNT);
      end
      free_head  = '0;
      list_empty = 1'b0;
      kernel_end = '0;
      errors     = 0;
    endfunction

    // first frame is the kernel end rounded up to 4 KiB, all wrapping at 32 bits
    function logic [31:0] frame_addr(logic [6:0] idx);
      logic [31:0] base;
      base = {kernel_end[31:12], 12'h000};
      if (base != kernel_end) base += 32'h1000;
      return base + (32'(idx) << pffl_pkg::PAGE_SHIFT);
    endfunction

    function frame_result_t take_request(logic [1:0] mode, logic [7:0] cnt,
                                         logic [6:0] ch, logic pres);
      frame_result_t r;
      logic [6:0]    cur;
      bit            fail;
      int            steps;
      r = '0;
      case (mode)
        pffl_pkg::MODE_ALLOC: begin
          if (cnt != 0 && !list_empty) begin
            cur  = free_head;
            fail = 1'b0;
            // short list: a tail shows up before the count is reached
            for (int i = 1; i < cnt; i++) begin
              if (frame_tail[cur]) begin
                fail = 1'b1;
                break;
              end
              cur = frame_next[cur];
            end
            if (!fail) begin
              r.ok           = 1'b1;
              r.head_index   = free_head;
              r.head_address = frame_addr(free_head);
              list_empty     = frame_tail[cur];
              free_head      = frame_tail[cur] ? 7'd0 : frame_next[cur];
              frame_tail[cur] = 1'b1;
              frame_next[cur] = '0;
            end
          end
        end
        pffl_pkg::MODE_FREE: begin
          if (!pres) begin
            r.ok = 1'b1;
          end else begin
            // walk bounded so a cyclic chain is refused
            cur   = ch;
            steps = 0;
            while (!frame_tail[cur] && steps < pffl_pkg::PAGE_COUNT) begin
              cur = frame_next[cur];
              steps++;
            end
            if (frame_tail[cur]) begin
              frame_tail[cur] = list_empty;
              frame_next[cur] = list_empty ? 7'd0 : free_head;
              free_head       = ch;
              list_empty      = 1'b0;
              r.ok            = 1'b1;
            end
          end
        end
        pffl_pkg::MODE_LINK: begin
          r.ok         = 1'b1;
          r.link_end   = frame_tail[ch];
          r.link_index = frame_tail[ch] ? 7'd0 : frame_next[ch];
        end
        default: ;
      endcase
      r.free_head_index = list_empty ? 7'd0 : free_head;
      r.free_empty      = list_empty;
      replies.push_back(r);
      return r;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(frame_result_t got);
      frame_result_t want;
      if (replies.size() == 0) begin
        $error("result transfer with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = replies.pop_front();
      cmp_field("ok", 32'(want.ok), 32'(got.ok));
      cmp_field("head_index", 32'(want.head_index), 32'(got.head_index));
      cmp_field("head_address", want.head_address, got.head_address);
      cmp_field("link_index", 32'(want.link_index), 32'(got.link_index));
      cmp_field("link_end", 32'(want.link_end), 32'(got.link_end));
      cmp_field("free_head_index", 32'(want.free_head_index), 32'(got.free_head_index));
      cmp_field("free_empty", 32'(want.free_empty), 32'(got.free_empty));
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // page_count[7:0], chain_head[14:8], chain_present[15]
  logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // ok, head_index, head_address, link_index, link_end,
                                    // free_head_index, free_empty
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  free_list_mirror sb = new();
  logic [6:0]      live_heads[$];   // heads of chains handed out and not yet given back
  bit              no_gaps = 1'b0;  // both sides run back to back while set
  int unsigned     idle_cycles = 0;
  int              rx_wait = 0;

  page_frame_free_list_allocator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // result side: check each transfer, then hold ready low for a random stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_reply(frame_result_t'(m_axis_tdata));
        rx_wait = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // one request transfer; the mirror is updated at the accepting edge
  task automatic issue(input logic [1:0] mode, input logic [7:0] cnt, input logic [6:0] ch,
                       input logic pres, output frame_result_t exp_res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pres, ch, cnt};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res = sb.take_request(mode, cnt, ch, pres);
  endtask

  // stop sending and wait until every result is back, block idle again
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // kernel end register, written only while the block is idle
  task automatic write_kernel_end(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.kernel_end = value;
  endtask

  // mostly allocate / give back whole chains; misuse also frees arbitrary entries
  task automatic random_item(input bit misuse);
    logic [1:0]    mode;
    logic [7:0]    cnt;
    logic [6:0]    ch;
    logic          pres;
    int            pick;
    int            k;
    frame_result_t res;
    mode = 2'($urandom);
    cnt  = 8'($urandom);
    ch   = 7'($urandom);
    pres = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      mode = pffl_pkg::MODE_ALLOC;
      k = $urandom_range(0, 19);
      cnt = (k < 14) ? 8'($urandom_range(1, 8)) :
            (k < 19) ? 8'($urandom_range(9, 40)) : 8'($urandom_range(41, 128));
    end else if (pick < 80) begin
      mode = pffl_pkg::MODE_FREE;
      pres = 1'b1;
      if (live_heads.size() > 0 && (!misuse || pick < 60)) begin
        k  = $urandom_range(0, live_heads.size() - 1);
        ch = live_heads[k];
        live_heads.delete(k);
      end else if (!misuse) begin
        mode = pffl_pkg::MODE_ALLOC;
        cnt  = 8'($urandom_range(1, 8));
      end
    end else if (pick < 90) begin
      mode = pffl_pkg::MODE_LINK;
    end else begin
      case (pick % 4)
        0: begin
          mode = pffl_pkg::MODE_ALLOC;
          cnt  = 8'd0;
        end
        1: begin
          mode = pffl_pkg::MODE_ALLOC;
          cnt  = 8'($urandom_range(129, 255));
        end
        2: begin
          mode = pffl_pkg::MODE_FREE;
          pres = 1'b0;
        end
        default: mode = MODE_IDLE;
      endcase
    end
    issue(mode, cnt, ch, pres, res);
    if (mode == pffl_pkg::MODE_ALLOC && res.ok) live_heads.push_back(res.head_index);
  endtask

  task automatic run_phase(input logic [31:0] kend, input int n, input bit misuse);
    write_kernel_end(kend);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      random_item(misuse);
    end
    drain();
  endtask

  initial begin
    frame_result_t res;
    logic [6:0]    a;
    logic [6:0]    b;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, kernel end at its reset value
    issue(pffl_pkg::MODE_LINK, 8'h00, 7'd0, 1'b0, res);
    issue(pffl_pkg::MODE_LINK, 8'hFF, 7'd127, 1'b1, res);
    issue(pffl_pkg::MODE_ALLOC, 8'd0, 7'h55, 1'b1, res);      // zero count
    issue(pffl_pkg::MODE_ALLOC, 8'd255, 7'h2A, 1'b0, res);    // list too short
    issue(pffl_pkg::MODE_ALLOC, 8'd129, 7'h00, 1'b1, res);
    issue(pffl_pkg::MODE_ALLOC, 8'd1, 7'h7F, 1'b0, res);
    a = res.head_index;
    issue(pffl_pkg::MODE_ALLOC, 8'd3, 7'h00, 1'b0, res);
    b = res.head_index;
    issue(pffl_pkg::MODE_FREE, 8'hAA, 7'h7F, 1'b0, res);      // null chain
    issue(MODE_IDLE, 8'h55, 7'h2A, 1'b1, res);                // unused mode
    issue(pffl_pkg::MODE_FREE, 8'h00, b, 1'b1, res);
    issue(pffl_pkg::MODE_FREE, 8'h00, a, 1'b1, res);
    issue(pffl_pkg::MODE_ALLOC, 8'd128, 7'h00, 1'b0, res);    // whole pool
    a = res.head_index;
    issue(pffl_pkg::MODE_ALLOC, 8'd1, 7'h00, 1'b0, res);      // empty list
    issue(pffl_pkg::MODE_LINK, 8'h00, 7'd127, 1'b0, res);
    issue(pffl_pkg::MODE_FREE, 8'h00, a, 1'b1, res);
    issue(pffl_pkg::MODE_ALLOC, 8'd127, 7'h00, 1'b0, res);
    a = res.head_index;
    issue(pffl_pkg::MODE_ALLOC, 8'd1, 7'h00, 1'b0, res);
    b = res.head_index;
    issue(pffl_pkg::MODE_ALLOC, 8'd1, 7'h00, 1'b0, res);
    issue(pffl_pkg::MODE_FREE, 8'h00, a, 1'b1, res);
    issue(pffl_pkg::MODE_FREE, 8'h00, b, 1'b1, res);
    drain();

    // well-formed traffic across several kernel end settings
    run_phase(32'hFFFF_FFFF, 350, 1'b0);
    run_phase(32'h0000_1000, 350, 1'b0);
    run_phase(32'hFFFF_F001, 350, 1'b0);
    run_phase(32'($urandom), 350, 1'b0);
    run_phase(32'h0000_0000, 250, 1'b0);

    // freeing the free list onto itself closes a cycle, the next free is refused
    write_kernel_end(32'($urandom));
    issue(pffl_pkg::MODE_FREE, 8'h00, sb.free_head, 1'b1, res);
    issue(pffl_pkg::MODE_FREE, 8'h00, sb.free_head, 1'b1, res);
    issue(pffl_pkg::MODE_ALLOC, 8'd5, 7'h00, 1'b0, res);
    issue(pffl_pkg::MODE_ALLOC, 8'd255, 7'h00, 1'b0, res);
    drain();
    run_phase(32'($urandom), 250, 1'b1);

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
